// ----- sv/tmwv_pkg.sv -----
// ----------------------------------------------------------------------------
// tmwv_pkg
// Shared types, constants and helpers of the tile map window validator.
// ----------------------------------------------------------------------------
package tmwv_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int TILE_W     = 4;
    localparam int CNT_W      = 17;
    localparam int DIM_W      = 9;
    localparam int MASK_W     = 16;
    localparam int FRAC_W     = 17;
    localparam int BOUND_W    = 16;
    localparam int EN_W       = 4;
    localparam int TOTAL_W    = 2 * DIM_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 112;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WATER_MASK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BUILD_MASK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPECIAL_CODES = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_EN      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_BUILD     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SUBST_RANGE   = 3'd7;

    // check enable bits
    localparam int EN_RIVER = 0;
    localparam int EN_COAST = 1;
    localparam int EN_ANOM  = 2;
    localparam int EN_DIST  = 3;

    // reset values of the registers
    localparam logic [DIM_W-1:0]      RST_MAP_WIDTH     = 9'd256;
    localparam logic [DIM_W-1:0]      RST_MAP_HEIGHT    = 9'd256;
    localparam logic [MASK_W-1:0]     RST_WATER_MASK    = 16'd14;
    localparam logic [MASK_W-1:0]     RST_BUILD_MASK    = 16'd0;
    localparam logic [11:0]           RST_SPECIAL_CODES = 12'd0;
    localparam logic [EN_W-1:0]       RST_CHECK_EN      = 4'hF;
    localparam logic [FRAC_W-1:0]     RST_MIN_BUILD     = 17'd32768;
    localparam logic [CFG_DATA_W-1:0] RST_SUBST_RANGE   = 32'd0;

    typedef struct packed {
        logic [DIM_W-1:0]   w_eff;
        logic [DIM_W-1:0]   h_eff;
        logic [MASK_W-1:0]  water_mask;
        logic [MASK_W-1:0]  build_mask;
        logic [TILE_W-1:0]  ocean;
        logic [TILE_W-1:0]  river;
        logic [TILE_W-1:0]  subst;
        logic [EN_W-1:0]    en;
        logic [FRAC_W-1:0]  min_frac;
        logic [BOUND_W-1:0] sub_lo;
        logic [BOUND_W-1:0] sub_hi;
    } cfg_t;

    typedef struct packed {
        logic [TILE_W-1:0] tile;
        logic              last;
        logic              gap_hit;
        logic              anom_hit;
    } item_t;

    typedef struct packed {
        logic [CNT_W-1:0] bc;
        logic [CNT_W-1:0] rc;
        logic [CNT_W-1:0] sc;
        logic [CNT_W-1:0] lc;
        logic [CNT_W-1:0] gc;
        logic [CNT_W-1:0] ac;
        logic             ocean_seen;
    } tally_t;

    typedef struct packed {
        logic [CNT_W-1:0] buildable_count;
        logic [CNT_W-1:0] river_count;
        logic [CNT_W-1:0] substrate_count;
        logic [CNT_W-1:0] land_count;
        logic [CNT_W-1:0] gap_count;
        logic [CNT_W-1:0] anomaly_count;
        logic             buildable_passed;
        logic             river_passed;
        logic             coastline_passed;
        logic             anomalies_passed;
        logic             distribution_passed;
        logic             all_passed;
    } res_t;

    // saturating increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v, input logic hit);
        logic [CNT_W-1:0] r;
        r = v;
        if (hit && (v != {CNT_W{1'b1}}))
        begin
            r = v + 1'b1;
        end
        return r;
    endfunction

endpackage

// ----- sv/tile_map_window_validator.sv -----
// ----------------------------------------------------------------------------
// tile_map_window_validator
// Tile map check: class counts, isolated tile search on a 3x3 window and
// ratio checks, one result per map.
// ----------------------------------------------------------------------------
// Throughput: one tile per cycle, but a map's last tile waits for room in
// the snapshot stage; the line store takes one read and one write per cycle,
// with write-to-read forwarding for the same column. Result path from a map's
// last tile: scan stage, count snapshot, product stage, result register.
// Reset: positions, counters, window and handshake state clear; registers
// take their defaults; the line store keeps its contents and is not cleared.
// ----------------------------------------------------------------------------
module tile_map_window_validator #(
    parameter int MAX_WIDTH  = tmwv_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = tmwv_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [tmwv_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [3:0] tile_type
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [16:0] buildable_count, [33:17] river_count, [50:34] substrate_count,
    // [67:51] land_count, [84:68] gap_count, [101:85] anomaly_count,
    // [102] buildable_passed, [103] river_passed, [104] coastline_passed,
    // [105] anomalies_passed, [106] distribution_passed, [107] all_passed
    output logic [tmwv_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                              cfg_wr_en,
    input  logic [tmwv_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tmwv_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tmwv_pkg::*;

    logic [DIM_W-1:0]      map_width_reg;
    logic [DIM_W-1:0]      map_height_reg;
    logic [MASK_W-1:0]     water_mask_reg;
    logic [MASK_W-1:0]     build_mask_reg;
    logic [11:0]           special_reg;
    logic [EN_W-1:0]       check_en_reg;
    logic [FRAC_W-1:0]     min_build_reg;
    logic [CFG_DATA_W-1:0] subst_range_reg;

    cfg_t   cfg;
    item_t  item;
    tally_t snap;
    res_t   res;

    logic   in_fire;
    logic   b_valid;
    logic   b_go;
    logic   c_free;
    logic   c_valid;
    logic   c_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg   <= RST_MAP_WIDTH;
            map_height_reg  <= RST_MAP_HEIGHT;
            water_mask_reg  <= RST_WATER_MASK;
            build_mask_reg  <= RST_BUILD_MASK;
            special_reg     <= RST_SPECIAL_CODES;
            check_en_reg    <= RST_CHECK_EN;
            min_build_reg   <= RST_MIN_BUILD;
            subst_range_reg <= RST_SUBST_RANGE;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MAP_WIDTH:     map_width_reg   <= cfg_data[DIM_W-1:0];
                REG_MAP_HEIGHT:    map_height_reg  <= cfg_data[DIM_W-1:0];
                REG_WATER_MASK:    water_mask_reg  <= cfg_data[MASK_W-1:0];
                REG_BUILD_MASK:    build_mask_reg  <= cfg_data[MASK_W-1:0];
                REG_SPECIAL_CODES: special_reg     <= cfg_data[11:0];
                REG_CHECK_EN:      check_en_reg    <= cfg_data[EN_W-1:0];
                REG_MIN_BUILD:     min_build_reg   <= cfg_data[FRAC_W-1:0];
                REG_SUBST_RANGE:   subst_range_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // zero size acts as one; oversize clamps to MAX_WIDTH (the line store size) and MAX_HEIGHT
    always_comb
    begin
        if (map_width_reg == '0)
        begin
            cfg.w_eff = DIM_W'(1);
        end
        else if (32'(map_width_reg) > MAX_WIDTH)
        begin
            cfg.w_eff = DIM_W'(MAX_WIDTH);
        end
        else
        begin
            cfg.w_eff = map_width_reg;
        end
        if (map_height_reg == '0)
        begin
            cfg.h_eff = DIM_W'(1);
        end
        else if (32'(map_height_reg) > MAX_HEIGHT)
        begin
            cfg.h_eff = DIM_W'(MAX_HEIGHT);
        end
        else
        begin
            cfg.h_eff = map_height_reg;
        end
        cfg.water_mask = water_mask_reg;
        cfg.build_mask = build_mask_reg;
        cfg.ocean      = special_reg[3:0];
        cfg.river      = special_reg[7:4];
        cfg.subst      = special_reg[11:8];
        cfg.en         = check_en_reg;
        cfg.min_frac   = min_build_reg;
        cfg.sub_lo     = subst_range_reg[15:0];
        cfg.sub_hi     = subst_range_reg[31:16];
    end

    // a tile that closes a map waits only for room in the snapshot stage
    assign b_go          = b_valid && (!item.last || c_free);
    assign s_axis_tready = !b_valid || b_go;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    tmwv_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .in_fire (in_fire),
        .in_tile (s_axis_tdata[TILE_W-1:0]),
        .go      (b_go),
        .b_valid (b_valid),
        .item    (item)
    );

    tmwv_tally u_tally (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .go      (b_go),
        .item    (item),
        .c_ready (c_ready),
        .c_free  (c_free),
        .c_valid (c_valid),
        .snap    (snap)
    );

    tmwv_verdict u_verdict (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .c_valid (c_valid),
        .snap    (snap),
        .c_ready (c_ready),
        .m_ready (m_axis_tready),
        .m_valid (m_axis_tvalid),
        .res     (res)
    );

    assign m_axis_tdata = {4'b0000,
                           res.all_passed,
                           res.distribution_passed,
                           res.anomalies_passed,
                           res.coastline_passed,
                           res.river_passed,
                           res.buildable_passed,
                           res.anomaly_count,
                           res.gap_count,
                           res.land_count,
                           res.substrate_count,
                           res.river_count,
                           res.buildable_count};

endmodule

// ----- sv/tmwv_ram.sv -----
// ----------------------------------------------------------------------------
// tmwv_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tmwv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/tmwv_scan.sv -----
// ----------------------------------------------------------------------------
// tmwv_scan
// Raster position, input register, line store and 3x3 window with the
// isolated tile detection of the window center.
// ----------------------------------------------------------------------------
module tmwv_scan #(
    parameter int MAX_WIDTH  = tmwv_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = tmwv_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tmwv_pkg::cfg_t                cfg,
    input  logic                          in_fire,
    input  logic [tmwv_pkg::TILE_W-1:0]   in_tile,
    input  logic                          go,
    output logic                          b_valid,
    output tmwv_pkg::item_t               item
);
    import tmwv_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int LINE_W = 2 * TILE_W;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              b_valid_reg, b_valid_next;
    logic [TILE_W-1:0] tile_reg;
    logic [COL_W-1:0]  x_reg;
    logic              last_reg;
    logic              judge_reg;
    logic              byp_reg;
    logic [LINE_W-1:0] byp_data_reg;
    logic [TILE_W-1:0] win_reg  [3][3];
    logic [TILE_W-1:0] win_next [3][3];

    logic              row_end;
    logic              map_end;
    logic              judge_now;
    logic [LINE_W-1:0] ram_rdata;
    logic [LINE_W-1:0] line;
    logic [LINE_W-1:0] wdata;
    logic              all_ocean;
    logic              all_first;

    always_comb
    begin
        row_end   = (32'(col_reg) + 32'd1) >= 32'(cfg.w_eff);
        map_end   = row_end && ((32'(row_reg) + 32'd1) >= 32'(cfg.h_eff));
        judge_now = (32'(col_reg) >= 32'd2) && (32'(row_reg) >= 32'd2);
        col_next  = col_reg;
        row_next  = row_reg;
        if (in_fire)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = map_end ? '0 : ROW_W'(row_reg + 1'b1);
            end
            else
            begin
                col_next = COL_W'(col_reg + 1'b1);
            end
        end
    end

    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (in_fire)
        begin
            b_valid_next = 1'b1;
        end
        else if (go)
        begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            b_valid_reg <= 1'b0;
            byp_reg     <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            b_valid_reg <= b_valid_next;
            if (in_fire)
            begin
                // the column being read is written back this very cycle
                byp_reg <= go && (col_reg == x_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            tile_reg     <= in_tile;
            x_reg        <= col_reg;
            last_reg     <= map_end;
            judge_reg    <= judge_now;
            byp_data_reg <= wdata;
        end
    end

    tmwv_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .clk   (clk),
        .we    (go),
        .waddr (x_reg),
        .wdata (wdata),
        .re    (in_fire),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    // upper row in the low nibble, middle row in the high nibble
    assign line  = byp_reg ? byp_data_reg : ram_rdata;
    assign wdata = {tile_reg, line[LINE_W-1:TILE_W]};

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = line[TILE_W-1:0];
        win_next[1][2] = line[LINE_W-1:TILE_W];
        win_next[2][2] = tile_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else if (go)
        begin
            win_reg <= win_next;
        end
    end

    always_comb
    begin
        all_ocean = 1'b1;
        all_first = 1'b1;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (!((r == 1) && (c == 1)))
                begin
                    if (win_next[r][c] != cfg.ocean)
                    begin
                        all_ocean = 1'b0;
                    end
                    if (win_next[r][c] != win_next[0][0])
                    begin
                        all_first = 1'b0;
                    end
                end
            end
        end
    end

    assign b_valid       = b_valid_reg;
    assign item.tile     = tile_reg;
    assign item.last     = last_reg;
    assign item.gap_hit  = judge_reg && all_ocean && (win_next[1][1] != cfg.ocean);
    assign item.anom_hit = judge_reg && all_first && (win_next[1][1] != win_next[0][0]);

endmodule

// ----- sv/tmwv_tally.sv -----
// ----------------------------------------------------------------------------
// tmwv_tally
// Class counters of the current map; snapshot of the totals at map end.
// ----------------------------------------------------------------------------
module tmwv_tally (
    input  logic             clk,
    input  logic             rst_n,
    input  tmwv_pkg::cfg_t   cfg,
    input  logic             go,
    input  tmwv_pkg::item_t  item,
    input  logic             c_ready,
    output logic             c_free,
    output logic             c_valid,
    output tmwv_pkg::tally_t snap
);
    import tmwv_pkg::*;

    tally_t cnt_reg, cnt_next;
    tally_t snap_reg;
    logic   c_valid_reg, c_valid_next;
    logic   water;

    always_comb
    begin
        water            = cfg.water_mask[item.tile];
        cnt_next.bc      = sat_inc(cnt_reg.bc, cfg.build_mask[item.tile]);
        cnt_next.rc      = sat_inc(cnt_reg.rc, item.tile == cfg.river);
        cnt_next.sc      = sat_inc(cnt_reg.sc, !water && (item.tile == cfg.subst));
        cnt_next.lc      = sat_inc(cnt_reg.lc, !water);
        cnt_next.gc      = sat_inc(cnt_reg.gc, item.gap_hit);
        cnt_next.ac      = sat_inc(cnt_reg.ac, item.anom_hit);
        cnt_next.ocean_seen = cnt_reg.ocean_seen || (item.tile == cfg.ocean);
    end

    always_comb
    begin
        c_valid_next = c_valid_reg;
        if (go && item.last)
        begin
            c_valid_next = 1'b1;
        end
        else if (c_ready)
        begin
            c_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= c_valid_next;
            if (go)
            begin
                // clear for the next map once the totals are handed on
                cnt_reg <= item.last ? '0 : cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && item.last)
        begin
            snap_reg <= cnt_next;
        end
    end

    assign c_free  = !c_valid_reg || c_ready;
    assign c_valid = c_valid_reg;
    assign snap    = snap_reg;

endmodule

// ----- sv/tmwv_verdict.sv -----
// ----------------------------------------------------------------------------
// tmwv_verdict
// Ratio products, threshold compares and the result register.
// ----------------------------------------------------------------------------
module tmwv_verdict (
    input  logic             clk,
    input  logic             rst_n,
    input  tmwv_pkg::cfg_t   cfg,
    input  logic             c_valid,
    input  tmwv_pkg::tally_t snap,
    output logic             c_ready,
    input  logic             m_ready,
    output logic             m_valid,
    output tmwv_pkg::res_t   res
);
    import tmwv_pkg::*;

    localparam int PB_W = FRAC_W + TOTAL_W;
    localparam int PS_W = BOUND_W + CNT_W;

    logic [TOTAL_W-1:0] total_reg;
    logic               d_valid_reg, d_valid_next;
    tally_t             d_cnt_reg;
    logic [PB_W-1:0]    pb_reg;
    logic [PS_W-1:0]    plo_reg;
    logic [PS_W-1:0]    phi_reg;
    logic               out_valid_reg, out_valid_next;
    res_t               res_reg, res_next;

    logic               d_ready;
    logic               load_d;
    logic               load_o;
    logic [PB_W-1:0]    b_scaled;
    logic [PS_W-1:0]    s_scaled;

    assign d_ready = !out_valid_reg || m_ready;
    assign c_ready = !d_valid_reg || d_ready;
    assign load_d  = c_valid && c_ready;
    assign load_o  = d_valid_reg && d_ready;

    always_comb
    begin
        d_valid_next = d_valid_reg;
        if (load_d)
        begin
            d_valid_next = 1'b1;
        end
        else if (d_ready)
        begin
            d_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (load_o)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg   <= d_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // tile total follows the size registers
    always_ff @(posedge clk)
    begin
        total_reg <= TOTAL_W'(cfg.w_eff) * TOTAL_W'(cfg.h_eff);
    end

    always_ff @(posedge clk)
    begin
        if (load_d)
        begin
            d_cnt_reg.bc         <= snap.bc;
            d_cnt_reg.rc         <= snap.rc;
            d_cnt_reg.sc         <= snap.sc;
            d_cnt_reg.lc         <= snap.lc;
            d_cnt_reg.gc         <= (cfg.en[EN_COAST] && snap.ocean_seen) ? snap.gc : '0;
            d_cnt_reg.ac         <= cfg.en[EN_ANOM] ? snap.ac : '0;
            d_cnt_reg.ocean_seen <= snap.ocean_seen;
            pb_reg               <= PB_W'(cfg.min_frac) * PB_W'(total_reg);
            plo_reg              <= PS_W'(cfg.sub_lo) * PS_W'(snap.lc);
            phi_reg              <= PS_W'(cfg.sub_hi) * PS_W'(snap.lc);
        end
    end

    always_comb
    begin
        b_scaled                    = PB_W'({d_cnt_reg.bc, 16'h0000});
        s_scaled                    = {d_cnt_reg.sc, 16'h0000};
        res_next.buildable_count    = d_cnt_reg.bc;
        res_next.river_count        = d_cnt_reg.rc;
        res_next.substrate_count    = d_cnt_reg.sc;
        res_next.land_count         = d_cnt_reg.lc;
        res_next.gap_count          = d_cnt_reg.gc;
        res_next.anomaly_count      = d_cnt_reg.ac;
        res_next.buildable_passed   = b_scaled >= pb_reg;
        res_next.river_passed       = !cfg.en[EN_RIVER] || (d_cnt_reg.rc != '0);
        res_next.coastline_passed   = d_cnt_reg.gc == '0;
        res_next.anomalies_passed   = d_cnt_reg.ac == '0;
        if (!cfg.en[EN_DIST])
        begin
            res_next.distribution_passed = 1'b1;
        end
        else if (d_cnt_reg.lc == '0)
        begin
            res_next.distribution_passed = cfg.sub_lo == '0;
        end
        else
        begin
            res_next.distribution_passed = (s_scaled >= plo_reg) && (s_scaled <= phi_reg);
        end
        res_next.all_passed = res_next.buildable_passed && res_next.river_passed
                              && res_next.coastline_passed && res_next.anomalies_passed
                              && res_next.distribution_passed;
    end

    always_ff @(posedge clk)
    begin
        if (load_o)
        begin
            res_reg <= res_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign res     = res_reg;

endmodule

// ----- tb/tile_map_window_validator_tb.sv -----
// ----------------------------------------------------------------------------
// tile_map_window_validator_tb
// Streams raster tile maps of many sizes and settings through the validator
// and compares every map report with a cycle-free model of the class counts,
// the 3x3 isolated-tile search and the ratio checks, under random stalls.
// ----------------------------------------------------------------------------
module tile_map_window_validator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tmwv_pkg::*;

    localparam int          MAX_W         = DEF_MAX_WIDTH;
    localparam int          MAX_H         = DEF_MAX_HEIGHT;
    localparam int          TILE_TARGET   = 1500;
    localparam int          REPORT_TARGET = 60;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          HOLD_CYCLES   = 300;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned COUNT_MAX     = (1 << CNT_W) - 1;
    localparam bit [EN_W-1:0] ALL_CHECKS  = '1;

    typedef enum int {K_BUILD, K_RIVER, K_SUBST, K_LAND, K_GAP, K_ANOM} class_kind_e;
    typedef enum int {FILL_NOISE, FILL_OCEAN_SPECKLE, FILL_PLAIN_SPECKLE, FILL_SPECIALS} fill_e;
    typedef enum int {SHAPE_ANY, SHAPE_SINGLE, SHAPE_WIDE, SHAPE_TALL} shape_e;

    class map_report_board;
        bit [DIM_W-1:0]   width_reg;
        bit [DIM_W-1:0]   height_reg;
        bit [MASK_W-1:0]  water_mask;
        bit [MASK_W-1:0]  build_mask;
        bit [11:0]        codes;
        bit [EN_W-1:0]    enables;
        bit [FRAC_W-1:0]  min_frac;
        bit [31:0]        sub_bounds;

        bit [TILE_W-1:0]  line_rows[2][MAX_W];
        bit [TILE_W-1:0]  win[3][3];
        int unsigned      col_pos;
        int unsigned      row_pos;
        int unsigned      class_count[6];
        bit               ocean_seen;

        res_t             reports_due[$];
        int unsigned      reports_seen;
        int unsigned      errors;

        function new();
            width_reg  = RST_MAP_WIDTH;
            height_reg = RST_MAP_HEIGHT;
            water_mask = RST_WATER_MASK;
            build_mask = RST_BUILD_MASK;
            codes      = RST_SPECIAL_CODES;
            enables    = RST_CHECK_EN;
            min_frac   = RST_MIN_BUILD;
            sub_bounds = RST_SUBST_RANGE;
            foreach (line_rows[i, j]) line_rows[i][j] = '0;
            foreach (win[i, j]) win[i][j] = '0;
            reports_seen = 0;
            errors = 0;
            clear_map();
        endfunction

        function void clear_map();
            col_pos = 0;
            row_pos = 0;
            foreach (class_count[i]) class_count[i] = 0;
            ocean_seen = 1'b0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input bit [31:0] v);
            case (idx)
                REG_MAP_WIDTH:     width_reg  = v[DIM_W-1:0];
                REG_MAP_HEIGHT:    height_reg = v[DIM_W-1:0];
                REG_WATER_MASK:    water_mask = v[MASK_W-1:0];
                REG_BUILD_MASK:    build_mask = v[MASK_W-1:0];
                REG_SPECIAL_CODES: codes      = v[11:0];
                REG_CHECK_EN:      enables    = v[EN_W-1:0];
                REG_MIN_BUILD:     min_frac   = v[FRAC_W-1:0];
                REG_SUBST_RANGE:   sub_bounds = v;
                default: ;
            endcase
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0) return 1;
            return (width_reg > MAX_W) ? MAX_W : width_reg;
        endfunction

        function int unsigned eff_height();
            if (height_reg == 0) return 1;
            return (height_reg > MAX_H) ? MAX_H : height_reg;
        endfunction

        function void bump(input class_kind_e k);
            if (class_count[k] < COUNT_MAX) class_count[k]++;
        endfunction

        // Advance the map by one accepted tile; queue a report at the map end.
        function void take_tile(input bit [TILE_W-1:0] t);
            int unsigned       w;
            int unsigned       h;
            bit [TILE_W-1:0]   ocean;
            bit [TILE_W-1:0]   river;
            bit [TILE_W-1:0]   subst;
            bit                all_ocean;
            bit                all_first;
            longint unsigned   total;
            longint unsigned   bc;
            longint unsigned   rc;
            longint unsigned   sc;
            longint unsigned   lc;
            longint unsigned   gc;
            longint unsigned   ac;
            longint unsigned   lo;
            longint unsigned   hi;
            bit                bp;
            bit                rp;
            bit                cp;
            bit                ap;
            bit                dp;
            res_t              rep;

            w = eff_width();
            h = eff_height();
            ocean = codes[3:0];
            river = codes[7:4];
            subst = codes[11:8];

            if (build_mask[t]) bump(K_BUILD);
            if (t == river) bump(K_RIVER);
            if (!water_mask[t])
            begin
                bump(K_LAND);
                if (t == subst) bump(K_SUBST);
            end
            if (t == ocean) ocean_seen = 1'b1;

            for (int r = 0; r < 3; r++)
            begin
                win[r][0] = win[r][1];
                win[r][1] = win[r][2];
            end
            win[0][2] = line_rows[0][col_pos];
            win[1][2] = line_rows[1][col_pos];
            win[2][2] = t;
            line_rows[0][col_pos] = line_rows[1][col_pos];
            line_rows[1][col_pos] = t;

            if (col_pos >= 2 && row_pos >= 2)
            begin
                all_ocean = 1'b1;
                all_first = 1'b1;
                for (int r = 0; r < 3; r++)
                    for (int c = 0; c < 3; c++)
                    begin
                        if (r != 1 || c != 1)
                        begin
                            if (win[r][c] != ocean) all_ocean = 1'b0;
                            if (win[r][c] != win[0][0]) all_first = 1'b0;
                        end
                    end
                if (win[1][1] != ocean && all_ocean) bump(K_GAP);
                if (win[1][1] != win[0][0] && all_first) bump(K_ANOM);
            end

            if (col_pos + 1 < w)
            begin
                col_pos++;
                return;
            end
            col_pos = 0;
            if (row_pos + 1 < h)
            begin
                row_pos++;
                return;
            end

            total = longint'(w) * h;
            bc = class_count[K_BUILD];
            rc = class_count[K_RIVER];
            sc = class_count[K_SUBST];
            lc = class_count[K_LAND];
            gc = (enables[EN_COAST] && ocean_seen) ? class_count[K_GAP] : 0;
            ac = enables[EN_ANOM] ? class_count[K_ANOM] : 0;
            lo = sub_bounds[15:0];
            hi = sub_bounds[31:16];
            bp = (bc * 65536) >= (min_frac * total);
            rp = !enables[EN_RIVER] || rc > 0;
            cp = (gc == 0);
            ap = (ac == 0);
            if (!enables[EN_DIST])
                dp = 1'b1;
            else if (lc == 0)
                dp = (lo == 0);
            else
                dp = (sc * 65536 >= lo * lc) && (sc * 65536 <= hi * lc);

            rep.buildable_count     = bc[CNT_W-1:0];
            rep.river_count         = rc[CNT_W-1:0];
            rep.substrate_count     = sc[CNT_W-1:0];
            rep.land_count          = lc[CNT_W-1:0];
            rep.gap_count           = gc[CNT_W-1:0];
            rep.anomaly_count       = ac[CNT_W-1:0];
            rep.buildable_passed    = bp;
            rep.river_passed        = rp;
            rep.coastline_passed    = cp;
            rep.anomalies_passed    = ap;
            rep.distribution_passed = dp;
            rep.all_passed          = bp && rp && cp && ap && dp;
            reports_due.push_back(rep);
            clear_map();
        endfunction

        function void compare_field(input string name, input logic [CNT_W-1:0] want,
                                    input logic [CNT_W-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_report(input logic [OUT_DATA_W-1:0] d);
            res_t want;

            if (reports_due.size() == 0)
            begin
                $error("map report arrived with no map outstanding");
                errors++;
                return;
            end
            want = reports_due.pop_front();
            reports_seen++;
            compare_field("buildable_count", want.buildable_count, d[16:0]);
            compare_field("river_count", want.river_count, d[33:17]);
            compare_field("substrate_count", want.substrate_count, d[50:34]);
            compare_field("land_count", want.land_count, d[67:51]);
            compare_field("gap_count", want.gap_count, d[84:68]);
            compare_field("anomaly_count", want.anomaly_count, d[101:85]);
            compare_field("buildable_passed", want.buildable_passed, d[102]);
            compare_field("river_passed", want.river_passed, d[103]);
            compare_field("coastline_passed", want.coastline_passed, d[104]);
            compare_field("anomalies_passed", want.anomalies_passed, d[105]);
            compare_field("distribution_passed", want.distribution_passed, d[106]);
            compare_field("all_passed", want.all_passed, d[107]);
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    map_report_board board = new();
    int unsigned     cycle_count = 0;
    int unsigned     tiles_sent = 0;
    int unsigned     hold_requests = 0;
    int unsigned     holds_served = 0;
    bit              no_idle = 1'b0;

    tile_map_window_validator #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tile_map_window_validator_tb failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            board.take_tile(s_axis_tdata[TILE_W-1:0]);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_report(m_axis_tdata);
    end

    function automatic int next_gap();
        int r;

        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side: random stalls, plus a long hold-off whenever one is requested
    initial
    begin : result_sink
        int gap;

        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_requests != holds_served)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_served++;
            end
            else
            begin
                gap = next_gap();
                if (gap > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
                m_axis_tready <= 1'b1;
                @(negedge clk);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_tile(input bit [TILE_W-1:0] t);
        int gap;

        gap = next_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'(t);
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        @(negedge clk);
        tiles_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (board.reports_due.size() != 0);
    endtask

    task automatic apply_settings(input bit [31:0] w, input bit [31:0] h,
                                  input bit [31:0] water, input bit [31:0] build,
                                  input bit [31:0] codes, input bit [31:0] en,
                                  input bit [31:0] minf, input bit [31:0] bounds);
        bit [31:0] vals[8];

        // let the last map's tail clear the pipeline before touching registers
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        vals[REG_MAP_WIDTH]     = w;
        vals[REG_MAP_HEIGHT]    = h;
        vals[REG_WATER_MASK]    = water;
        vals[REG_BUILD_MASK]    = build;
        vals[REG_SPECIAL_CODES] = codes;
        vals[REG_CHECK_EN]      = en;
        vals[REG_MIN_BUILD]     = minf;
        vals[REG_SUBST_RANGE]   = bounds;
        for (int i = 0; i < 8; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            board.set_reg(CFG_IDX_W'(i), vals[i]);
            @(negedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_settings(input shape_e shape);
        bit [31:0] w;
        bit [31:0] h;
        bit [31:0] water;
        bit [31:0] build;
        bit [31:0] en;
        bit [31:0] minf;
        bit [31:0] bounds;
        bit [15:0] lo;
        bit [15:0] hi;

        case (shape)
            SHAPE_SINGLE:
            begin
                w = $urandom_range(0, 1);
                h = $urandom_range(0, 1);
            end
            SHAPE_WIDE:
            begin
                case ($urandom_range(0, 2))
                    0:       w = MAX_W;
                    1:       w = 511;
                    default: w = $urandom_range(MAX_W + 1, 511);
                endcase
                h = $urandom_range(1, 2);
            end
            SHAPE_TALL:
            begin
                w = $urandom_range(1, 2);
                h = $urandom_range(MAX_H, 511);
            end
            default:
            begin
                case ($urandom_range(0, 19))
                    0: begin w = 0; h = $urandom_range(1, 12); end
                    1: begin w = $urandom_range(3, 12); h = 0; end
                    2: begin w = $urandom_range(1, 2); h = $urandom_range(1, 2); end
                    3: begin w = $urandom_range(9, 30); h = $urandom_range(3, 6); end
                    default: begin w = $urandom_range(3, 8); h = $urandom_range(3, 8); end
                endcase
            end
        endcase

        case ($urandom_range(0, 5))
            0:       water = 0;
            1:       water = 16'hFFFF;
            default: water = $urandom_range(0, 16'hFFFF);
        endcase
        case ($urandom_range(0, 5))
            0:       build = 0;
            1:       build = 16'hFFFF;
            default: build = $urandom_range(0, 16'hFFFF);
        endcase
        en = $urandom_range(0, 1) ? 32'(ALL_CHECKS) : $urandom_range(0, 15);
        case ($urandom_range(0, 7))
            0:       minf = 0;
            1:       minf = 65536;
            2:       minf = 131071;
            default: minf = $urandom_range(0, 65536);
        endcase
        case ($urandom_range(0, 5))
            0: bounds = 0;
            1: bounds = 32'hFFFF_FFFF;
            2: bounds = $urandom();
            3:
            begin
                hi = $urandom_range(0, 16'hFFFF);
                bounds = {hi, 16'h0000};
            end
            default:
            begin
                lo = $urandom_range(0, 20000);
                hi = $urandom_range(lo, 16'hFFFF);
                bounds = {hi, lo};
            end
        endcase
        apply_settings(w, h, water, build, $urandom_range(0, 4095), en, minf, bounds);
    endtask

    task automatic send_map();
        int unsigned     area;
        fill_e           fill;
        bit [TILE_W-1:0] bg;
        bit [TILE_W-1:0] t;

        area = board.eff_width() * board.eff_height();
        fill = fill_e'($urandom_range(0, 3));
        bg = (fill == FILL_OCEAN_SPECKLE) ? board.codes[3:0] : TILE_W'($urandom_range(0, 15));
        for (int i = 0; i < area; i++)
        begin
            t = TILE_W'($urandom_range(0, 15));
            case (fill)
                FILL_OCEAN_SPECKLE, FILL_PLAIN_SPECKLE:
                    if ($urandom_range(0, 5) != 0) t = bg;
                FILL_SPECIALS:
                    case ($urandom_range(0, 3))
                        0: t = board.codes[3:0];
                        1: t = board.codes[7:4];
                        2: t = board.codes[11:8];
                        default: ;
                    endcase
                default: ;
            endcase
            send_tile(t);
        end
    endtask

    task automatic directed_maps();
        // tile ringed by ocean: both a coastline gap and an anomaly
        apply_settings(3, 3, 16'h0002, 16'h8001, 12'h321, ALL_CHECKS, 0, 0);
        for (int i = 0; i < 9; i++) send_tile((i == 4) ? 4'd15 : 4'd1);
        // anomaly with its check off; no ocean in the map
        apply_settings(3, 3, 16'h0002, 16'h8001, 12'h321,
                       (1 << EN_COAST) | (1 << EN_DIST), 0, 0);
        for (int i = 0; i < 9; i++) send_tile((i == 4) ? 4'd0 : 4'd4);
        // zero sizes act as one tile per map; buildable share hits the bound
        // exactly; everything is water, so there is no land
        apply_settings(0, 0, 16'hFFFF, 16'h8001, 12'h3F1, ALL_CHECKS, 65536, 1);
        send_tile(4'd15);
        send_tile(4'd0);
        // substrate share sits exactly on both bounds
        apply_settings(2, 1, 16'h0000, 16'h0000, 12'h321, ALL_CHECKS, 0, 32'h8000_8000);
        send_tile(4'd3);
        send_tile(4'd5);
    endtask

    initial
    begin : stimulus
        int phase;
        int maps;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed_maps();

        phase = 0;
        while (tiles_sent < TILE_TARGET || board.reports_seen < REPORT_TARGET)
        begin
            case (phase)
                2:
                begin
                    // single-tile maps at full rate against a stalled output
                    random_settings(SHAPE_SINGLE);
                    no_idle = 1'b1;
                    hold_requests++;
                    repeat (60) send_map();
                end
                4:
                begin
                    random_settings(SHAPE_WIDE);
                    send_map();
                end
                7:
                begin
                    random_settings(SHAPE_TALL);
                    send_map();
                end
                default:
                begin
                    random_settings(SHAPE_ANY);
                    no_idle = ($urandom_range(0, 4) == 0);
                    maps = (board.eff_width() * board.eff_height() > 100) ? 1 :
                           $urandom_range(1, 5);
                    repeat (maps)
                    begin
                        if ($urandom_range(0, 9) == 0) drain_results();
                        send_map();
                    end
                end
            endcase
            phase++;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (board.errors == 0 && board.reports_due.size() == 0)
            $display("tile_map_window_validator_tb passed");
        else
            $display("tile_map_window_validator_tb failed");
        $finish;
    end

endmodule
